// File: hw/rtl/sirt_pkg.sv
// Shared types and constants for the signed integer to radix text block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sirt_pkg;

  // Field and register widths
  localparam int VALUE_W      = 32;
  localparam int CHAR_W       = 8;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 1;
  localparam int ALPHA_SLOTS  = 16;
  localparam int SLOT_W       = 4;
  localparam int MAX_BASE_DEF = 16;

  // Divider schedule: quotient bits per cycle, cycles per digit
  localparam int BITS_PER_CYC = 8;
  localparam int DIV_CYCLES   = VALUE_W / BITS_PER_CYC;
  localparam int CNT_W        = $clog2(DIV_CYCLES);

  // Digit stack
  localparam int MAX_DIGITS = VALUE_W;
  localparam int PTR_W      = $clog2(MAX_DIGITS);
  localparam int ND_W       = PTR_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 1'b1;

  // Special characters
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // Digit alphabet, slot 0 in the low byte
  typedef logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] alpha_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } sirt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic digit_end;
    logic quo_zero;
    logic digits_full;
    logic out_free;
    logic emit_last;
  } sirt_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/sirt_in_if.sv
// Input channel: one signed value per item, valid/ready handshake.
// Depends on sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sirt_in_if;
  import sirt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sirt_out_if.sv
// Result channel: one character per item plus end-of-text flag.
// Depends on sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sirt_out_if;
  import sirt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sirt_cfg.sv
// Alphabet registers and alphabet check (length, forbidden and repeated characters).
// Depends on sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirt_cfg #(
  parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sirt_pkg::CFG_W-1:0]         cfg_wdata,
  output sirt_pkg::alpha_t                   alpha,
  output logic [$clog2(MAX_BASE+1)-1:0]      alpha_len,
  output logic                               alpha_ok
);
  import sirt_pkg::*;

  localparam int LEN_W = $clog2(MAX_BASE + 1);

  logic [CFG_W-1:0] alpha_low_r;
  logic [CFG_W-1:0] alpha_high_r;
  logic [LEN_W-1:0] len;
  logic             found;
  logic             bad;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_LOW:  alpha_low_r  <= cfg_wdata;
        REG_ALPHA_HIGH: alpha_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign alpha = alpha_t'({alpha_high_r, alpha_low_r});

  // Length: first NUL byte, else MAX_BASE
  always_comb begin
    len   = LEN_W'(MAX_BASE);
    found = 1'b0;
    for (int i = 0; i < MAX_BASE; i++) begin
      if (!found && alpha[i] == CHAR_NUL) begin
        len   = LEN_W'(i);
        found = 1'b1;
      end
    end
  end

  // Sign characters or duplicates among the used slots
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < MAX_BASE; i++) begin
      if (LEN_W'(i) < len) begin
        if (alpha[i] == CHAR_PLUS || alpha[i] == CHAR_MINUS) bad = 1'b1;
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (LEN_W'(j) < len && alpha[i] == alpha[j]) bad = 1'b1;
        end
      end
    end
  end

  assign alpha_len = len;
  assign alpha_ok  = (len >= LEN_W'(2)) && !bad;

endmodule

`default_nettype wire

// File: hw/rtl/sirt_ctrl.sv
// Controller: accept, divide-per-digit and emit sequencing.
// Depends on sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 alpha_ok,
  input  sirt_pkg::sirt_stat_t stat,
  output sirt_pkg::sirt_cmd_t  cmd
);
  import sirt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // an invalid alphabet drops the item
        if (in_valid && alpha_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.digit_end && (stat.quo_zero || stat.digits_full)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sirt_dp.sv
// Datapath: magnitude, shared 8-bit-per-cycle radix divider, digit stack,
// output register. Depends on sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirt_dp #(
  parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sirt_pkg::sirt_cmd_t                 cmd,
  output sirt_pkg::sirt_stat_t                stat,
  input  logic signed [sirt_pkg::VALUE_W-1:0] in_value,
  input  sirt_pkg::alpha_t                    alpha,
  input  logic [$clog2(MAX_BASE+1)-1:0]       alpha_len,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sirt_pkg::CHAR_W-1:0]         out_character,
  output logic                                out_last_char
);
  import sirt_pkg::*;

  localparam int LEN_W = $clog2(MAX_BASE + 1);
  localparam int DIG_W = $clog2(MAX_BASE);
  localparam int TW    = DIG_W + 1;

  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag;
  logic               neg;

  logic [VALUE_W-1:0] w_r;
  logic [DIG_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ND_W-1:0]    nd_r;
  logic [LEN_W-1:0]   len_r;
  logic               neg_pend_r;
  logic [DIG_W-1:0]   digits_r [MAX_DIGITS];

  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;
  logic               out_valid_r;

  logic [VALUE_W-1:0] w_step;
  logic [DIG_W-1:0]   rem_step;
  logic [TW-1:0]      trial;
  logic               ge;
  logic               step_last;
  logic [PTR_W-1:0]   rd_ptr;

  // Magnitude; the most negative value maps to 2^31 exactly
  assign raw = VALUE_W'(unsigned'(in_value));
  assign neg = raw[VALUE_W-1];
  assign mag = neg ? (VALUE_W'(0) - raw) : raw;

  // Restoring division, BITS_PER_CYC quotient bits per cycle
  always_comb begin
    w_step   = w_r;
    rem_step = rem_r;
    trial    = '0;
    ge       = 1'b0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      trial    = {rem_step, w_step[VALUE_W-1]};
      ge       = trial >= TW'(len_r);
      w_step   = {w_step[VALUE_W-2:0], ge};
      rem_step = ge ? DIG_W'(trial - TW'(len_r)) : DIG_W'(trial);
    end
  end

  assign step_last = (cnt_r == CNT_W'(DIV_CYCLES - 1));
  assign rd_ptr    = PTR_W'(nd_r - ND_W'(1));

  // Status to controller
  assign stat.digit_end   = step_last;
  assign stat.quo_zero    = (w_step == '0);
  assign stat.digits_full = (nd_r == ND_W'(MAX_DIGITS - 1));
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.emit_last   = !neg_pend_r && (nd_r == ND_W'(1));

  // Divider and stack control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      nd_r       <= '0;
      neg_pend_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r      <= '0;
      nd_r       <= '0;
      neg_pend_r <= neg;
    end else if (cmd.div_step) begin
      if (step_last) begin
        cnt_r <= '0;
        nd_r  <= nd_r + ND_W'(1);
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end else if (cmd.emit) begin
      if (neg_pend_r) neg_pend_r <= 1'b0;
      else            nd_r       <= nd_r - ND_W'(1);
    end
  end

  // Dividend/quotient and remainder; remainder restarts per digit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r   <= mag;
      rem_r <= '0;
      len_r <= alpha_len;
    end else if (cmd.div_step) begin
      w_r   <= w_step;
      rem_r <= step_last ? '0 : rem_step;
    end
  end

  // Digit stack, least significant digit first
  always_ff @(posedge clk) begin
    if (cmd.div_step && step_last) digits_r[nd_r[PTR_W-1:0]] <= rem_step;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Top of the digit stack is read here, straight into the output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (neg_pend_r) begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= alpha[SLOT_W'(digits_r[rd_ptr])];
        out_last_r <= (nd_r == ND_W'(1));
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

  // An emit always has a character left to send
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (neg_pend_r || nd_r != '0))
    else $error("emit with empty digit stack");

  // The stack never overflows during division
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (nd_r < ND_W'(MAX_DIGITS)))
    else $error("digit stack overflow");

  // Remainder stays below the radix while dividing
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (TW'(rem_r) < TW'(len_r)))
    else $error("remainder not below radix");

  // A new item starts with a clean divider
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cnt_r == '0 && rem_r == '0 && nd_r == '0))
    else $error("divider not cleared at load");

endmodule

`default_nettype wire

// File: hw/rtl/signed_integer_to_radix_text_top.sv
// Signed integer to radix text: top level with alphabet registers,
// controller and datapath. Depends on sirt_pkg, sirt_in_if, sirt_out_if,
// sirt_cfg, sirt_ctrl, sirt_dp.
//
// Usage:
//  - in_ch carries one signed 32-bit value per item (valid/ready).
//  - out_ch carries one character per item, most significant first, with a
//    leading '-' for negative values; last_char marks the final one.
//  - cfg_we/cfg_index/cfg_wdata write the two alphabet words (index 0: digit
//    characters 0..7, index 1: 8..15). Radix = position of the first NUL
//    byte, else MAX_BASE. A bad alphabet (radix under 2, '+' or '-', a
//    repeated character) makes each item vanish without output.
//  - One value at a time. Each digit is a full pass of the shared divider
//    (8 quotient bits per cycle), then characters leave at one per cycle
//    while the receiver is ready.
//  - A stalled receiver holds the output register and pauses emission; the
//    controller is back in idle for the next value in the cycle after the
//    last character is registered, even before the receiver has taken it.
//  - Reset clears the alphabet to zero (invalid) and empties the block.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_radix_text_top #(
  parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sirt_in_if.sink                        in_ch,
  sirt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sirt_pkg::CFG_W-1:0]     cfg_wdata
);
  import sirt_pkg::*;

  localparam int LEN_W = $clog2(MAX_BASE + 1);

  alpha_t           alpha;
  logic [LEN_W-1:0] alpha_len;
  logic             alpha_ok;
  sirt_cmd_t        cmd;
  sirt_stat_t       stat;

  // Alphabet registers and check
  sirt_cfg #(.MAX_BASE(MAX_BASE)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .alpha     (alpha),
    .alpha_len (alpha_len),
    .alpha_ok  (alpha_ok)
  );

  // Sequencer
  sirt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .alpha_ok (alpha_ok),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Divider, digit stack and output register
  sirt_dp #(.MAX_BASE(MAX_BASE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_ch.value),
    .alpha         (alpha),
    .alpha_len     (alpha_len),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last_char (out_ch.last_char)
  );

endmodule

`default_nettype wire
